@@ design/crc_framed_packet_receiver_unit_defines.svh @@
// ---------------------------------------------------------------------------
// crc framed packet receiver assertion macros
// shared property forms for the frame checks
// ---------------------------------------------------------------------------
`ifndef CRC_FRAMED_PACKET_RECEIVER_UNIT_DEFINES_SVH
`define CRC_FRAMED_PACKET_RECEIVER_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define CFPR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define CFPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/cfpr_pkg.sv @@
// ---------------------------------------------------------------------------
// cfpr_pkg
// types, codes and the byte-wide crc-32 update for the frame receiver
// ---------------------------------------------------------------------------
`default_nettype none

package cfpr_pkg;

  localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  localparam logic [7:0]  START_BYTE_RST   = 8'hA5;
  localparam logic [15:0] LENGTH_LIMIT_RST = 16'd256;
  localparam logic [15:0] TIMEOUT_RST      = 16'd300;

  localparam logic [15:0] IDLE_MAX = 16'hFFFF;

  // input opcodes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // result events
  localparam logic [2:0] EV_PAYLOAD = 3'd0;
  localparam logic [2:0] EV_GOOD    = 3'd1;
  localparam logic [2:0] EV_BADCRC  = 3'd2;
  localparam logic [2:0] EV_TOOLONG = 3'd3;
  localparam logic [2:0] EV_TIMEOUT = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_START_BYTE   = 2'd0;
  localparam logic [1:0] CFG_LENGTH_LIMIT = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT      = 2'd2;

  typedef enum logic [3:0] {
    PH_IDLE = 4'd0,
    PH_CMD  = 4'd1,
    PH_LEN1 = 4'd2,
    PH_LEN2 = 4'd3,
    PH_DATA = 4'd4,
    PH_CRC1 = 4'd5,
    PH_CRC2 = 4'd6,
    PH_CRC3 = 4'd7,
    PH_CRC4 = 4'd8
  } phase_t;

  typedef struct packed {
    logic       opcode;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic [7:0]  command;
    logic [15:0] frame_length;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  start_byte;
    logic [15:0] length_limit;
    logic [15:0] timeout_ticks;
  } cfg_t;

  // msb-first crc-32 over one byte, unrolled over its eight bits
  function automatic logic [31:0] crc_feed(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {b, 24'h00_0000};
    for (int k = 0; k < 8; k++) begin
      c = c[31] ? ({c[30:0], 1'b0} ^ CRC_POLY) : {c[30:0], 1'b0};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ design/cfpr_cfg.sv @@
// ---------------------------------------------------------------------------
// cfpr_cfg
// configuration registers: start byte, length limit and idle timeout
// ---------------------------------------------------------------------------
`default_nettype none

module cfpr_cfg (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [15:0]   cfg_wdata,
  output cfpr_pkg::cfg_t     cfg
);

  cfpr_pkg::cfg_t cfg_r;
  cfpr_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        cfpr_pkg::CFG_START_BYTE:   cfg_nxt.start_byte    = cfg_wdata[7:0];
        cfpr_pkg::CFG_LENGTH_LIMIT: cfg_nxt.length_limit  = cfg_wdata;
        cfpr_pkg::CFG_TIMEOUT:      cfg_nxt.timeout_ticks = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_byte    <= cfpr_pkg::START_BYTE_RST;
      cfg_r.length_limit  <= cfpr_pkg::LENGTH_LIMIT_RST;
      cfg_r.timeout_ticks <= cfpr_pkg::TIMEOUT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

@@ design/cfpr_in_reg.sv @@
// ---------------------------------------------------------------------------
// cfpr_in_reg
// input register stage, refilled in the cycle its item moves on
// ---------------------------------------------------------------------------
`default_nettype none

module cfpr_in_reg (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire cfpr_pkg::in_item_t in_data,
  input  wire logic               take,
  output logic                    item_vld,
  output cfpr_pkg::in_item_t      item
);

  logic               vld_r;
  logic               vld_nxt;
  cfpr_pkg::in_item_t item_r;

  assign in_ready = !vld_r || take;
  assign vld_nxt  = (in_valid && in_ready) ? 1'b1 : (take ? 1'b0 : vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
  end

  assign item_vld = vld_r;
  assign item     = item_r;

endmodule

`default_nettype wire

@@ design/cfpr_frame.sv @@
// ---------------------------------------------------------------------------
// cfpr_frame
// frame state machine, running crc, idle timer and result forming
// ---------------------------------------------------------------------------
`default_nettype none
`include "crc_framed_packet_receiver_unit_defines.svh"

module cfpr_frame (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cfpr_pkg::cfg_t     cfg,
  input  wire logic               item_vld,
  input  wire cfpr_pkg::in_item_t item,
  input  wire logic               out_free,
  output logic                    take,
  output logic                    res_vld,
  output cfpr_pkg::out_item_t     res
);

  cfpr_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]       cmd_r, cmd_nxt;
  logic [15:0]      len_r, len_nxt;
  logic [15:0]      pos_r, pos_nxt;
  logic [31:0]      crc_r, crc_nxt;
  logic [31:0]      rcrc_r, rcrc_nxt;
  logic [15:0]      idle_r, idle_nxt;

  logic [31:0] crc_fed;
  logic [15:0] pos_inc;
  logic [15:0] idle_inc;
  logic [15:0] len_full;
  logic [31:0] rcrc_full;
  logic        frame_open;
  logic [2:0]  ev;
  logic [7:0]  pb;
  logic [15:0] pi;

  assign crc_fed   = cfpr_pkg::crc_feed(crc_r, item.rx_byte);
  assign pos_inc   = pos_r + 16'd1;
  assign idle_inc  = (idle_r != cfpr_pkg::IDLE_MAX) ? (idle_r + 16'd1) : idle_r;
  assign len_full  = {item.rx_byte, len_r[7:0]};
  assign rcrc_full = {item.rx_byte, rcrc_r[23:0]};
  assign frame_open = (phase_r == cfpr_pkg::PH_CMD)  || (phase_r == cfpr_pkg::PH_LEN1) ||
                      (phase_r == cfpr_pkg::PH_LEN2) || (phase_r == cfpr_pkg::PH_DATA) ||
                      (phase_r == cfpr_pkg::PH_CRC1) || (phase_r == cfpr_pkg::PH_CRC2) ||
                      (phase_r == cfpr_pkg::PH_CRC3) || (phase_r == cfpr_pkg::PH_CRC4);

  always_comb begin
    phase_nxt = phase_r;
    cmd_nxt   = cmd_r;
    len_nxt   = len_r;
    pos_nxt   = pos_r;
    crc_nxt   = crc_r;
    rcrc_nxt  = rcrc_r;
    idle_nxt  = idle_r;
    res_vld   = 1'b0;
    ev        = cfpr_pkg::EV_PAYLOAD;
    pb        = 8'h00;
    pi        = 16'h0000;
    if (item.opcode == cfpr_pkg::OP_TICK) begin
      idle_nxt = idle_inc;
      if ((idle_inc > cfg.timeout_ticks) && frame_open) begin
        phase_nxt = cfpr_pkg::PH_IDLE;
        res_vld   = 1'b1;
        ev        = cfpr_pkg::EV_TIMEOUT;
      end else if (!frame_open) begin
        phase_nxt = cfpr_pkg::PH_IDLE;
      end
    end else begin
      idle_nxt = 16'h0000;
      case (phase_r)
        cfpr_pkg::PH_CMD: begin
          cmd_nxt   = item.rx_byte;
          crc_nxt   = crc_fed;
          phase_nxt = cfpr_pkg::PH_LEN1;
        end
        cfpr_pkg::PH_LEN1: begin
          len_nxt   = {8'h00, item.rx_byte};
          crc_nxt   = crc_fed;
          phase_nxt = cfpr_pkg::PH_LEN2;
        end
        cfpr_pkg::PH_LEN2: begin
          len_nxt = len_full;
          crc_nxt = crc_fed;
          if (len_full >= cfg.length_limit) begin
            phase_nxt = cfpr_pkg::PH_IDLE;
            res_vld   = 1'b1;
            ev        = cfpr_pkg::EV_TOOLONG;
          end else if (len_full == 16'h0000) begin
            phase_nxt = cfpr_pkg::PH_CRC1;
          end else begin
            phase_nxt = cfpr_pkg::PH_DATA;
          end
        end
        cfpr_pkg::PH_DATA: begin
          crc_nxt = crc_fed;
          pos_nxt = pos_inc;
          if (pos_inc >= len_r) begin
            phase_nxt = cfpr_pkg::PH_CRC1;
          end
          res_vld = 1'b1;
          ev      = cfpr_pkg::EV_PAYLOAD;
          pb      = item.rx_byte;
          pi      = pos_r;
        end
        cfpr_pkg::PH_CRC1: begin
          rcrc_nxt  = {24'h00_0000, item.rx_byte};
          phase_nxt = cfpr_pkg::PH_CRC2;
        end
        cfpr_pkg::PH_CRC2: begin
          rcrc_nxt  = {16'h0000, item.rx_byte, rcrc_r[7:0]};
          phase_nxt = cfpr_pkg::PH_CRC3;
        end
        cfpr_pkg::PH_CRC3: begin
          rcrc_nxt  = {8'h00, item.rx_byte, rcrc_r[15:0]};
          phase_nxt = cfpr_pkg::PH_CRC4;
        end
        cfpr_pkg::PH_CRC4: begin
          rcrc_nxt  = rcrc_full;
          phase_nxt = cfpr_pkg::PH_IDLE;
          res_vld   = 1'b1;
          ev        = (rcrc_full == crc_r) ? cfpr_pkg::EV_GOOD : cfpr_pkg::EV_BADCRC;
        end
        default: begin
          // idle, and any unused code falls back to idle
          phase_nxt = cfpr_pkg::PH_IDLE;
          if (item.rx_byte == cfg.start_byte) begin
            phase_nxt = cfpr_pkg::PH_CMD;
            cmd_nxt   = 8'h00;
            len_nxt   = 16'h0000;
            pos_nxt   = 16'h0000;
            crc_nxt   = cfpr_pkg::CRC_INIT;
            rcrc_nxt  = 32'h0000_0000;
          end
        end
      endcase
    end
  end

  // an item moves on unless its result would land on a stalled output register
  assign take = item_vld && (!res_vld || out_free);

  assign res.event_res     = ev;
  assign res.payload_byte  = pb;
  assign res.payload_index = pi;
  assign res.command       = cmd_nxt;
  assign res.frame_length  = len_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= cfpr_pkg::PH_IDLE;
      cmd_r   <= 8'h00;
      len_r   <= 16'h0000;
      pos_r   <= 16'h0000;
      crc_r   <= cfpr_pkg::CRC_INIT;
      rcrc_r  <= 32'h0000_0000;
      idle_r  <= 16'h0000;
    end else if (take) begin
      phase_r <= phase_nxt;
      cmd_r   <= cmd_nxt;
      len_r   <= len_nxt;
      pos_r   <= pos_nxt;
      crc_r   <= crc_nxt;
      rcrc_r  <= rcrc_nxt;
      idle_r  <= idle_nxt;
    end
  end

  `CFPR_ASSERT_NOW(a_payload_only_in_data,
    take && res_vld && (ev == cfpr_pkg::EV_PAYLOAD), phase_r == cfpr_pkg::PH_DATA,
    "payload item outside the data phase")
  `CFPR_ASSERT_NOW(a_verdict_only_at_crc_end,
    take && res_vld && ((ev == cfpr_pkg::EV_GOOD) || (ev == cfpr_pkg::EV_BADCRC)),
    phase_r == cfpr_pkg::PH_CRC4, "crc verdict before the last crc byte")
  `CFPR_ASSERT_NEXT(a_start_seeds_crc,
    take && (phase_r == cfpr_pkg::PH_IDLE) && (item.opcode == cfpr_pkg::OP_BYTE) &&
    (item.rx_byte == cfg.start_byte),
    (phase_r == cfpr_pkg::PH_CMD) && (crc_r == cfpr_pkg::CRC_INIT),
    "frame start did not seed the crc")
  `CFPR_ASSERT_NEXT(a_tick_never_lowers_idle,
    take && (item.opcode == cfpr_pkg::OP_TICK), idle_r >= $past(idle_r),
    "idle count fell on a tick")

endmodule

`default_nettype wire

@@ design/cfpr_out_reg.sv @@
// ---------------------------------------------------------------------------
// cfpr_out_reg
// result register on the output channel
// ---------------------------------------------------------------------------
`default_nettype none

module cfpr_out_reg (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                load,
  input  wire cfpr_pkg::out_item_t res,
  output logic                     out_free,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output cfpr_pkg::out_item_t      out_data
);

  logic                valid_r;
  logic                valid_nxt;
  cfpr_pkg::out_item_t data_r;

  assign out_free  = !valid_r || out_ready;
  assign valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

@@ design/crc_framed_packet_receiver_unit.sv @@
// a result is shown from the result register, after its item passes the input register
// throughput: one item per cycle, except while a result waits on a full result register;
// the crc-32 byte update is one unrolled xor network; an item that gives a result waits
// in the input register only while the result register is full and not being taken
// reset (rst_n low, synchronous): idle, crc all ones, counters clear, registers to defaults
// ---------------------------------------------------------------------------
// crc_framed_packet_receiver_unit
// deframes start/command/length/payload/crc-32 byte streams with idle timeout
// ---------------------------------------------------------------------------
`default_nettype none

module crc_framed_packet_receiver_unit (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire cfpr_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output cfpr_pkg::out_item_t      out_data,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [15:0]         cfg_wdata
);

  cfpr_pkg::cfg_t      cfg;
  cfpr_pkg::in_item_t  item;
  cfpr_pkg::out_item_t res;
  logic                item_vld;
  logic                take;
  logic                res_vld;
  logic                out_free;

  cfpr_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  cfpr_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .take     (take),
    .item_vld (item_vld),
    .item     (item)
  );

  cfpr_frame u_frame (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .item_vld (item_vld),
    .item     (item),
    .out_free (out_free),
    .take     (take),
    .res_vld  (res_vld),
    .res      (res)
  );

  cfpr_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (take && res_vld),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ sim/crc_framed_packet_receiver_unit_tb.sv @@
// ---------------------------------------------------------------------------
// crc framed packet receiver testbench
// drives framed byte streams and time ticks through the receiver under several
// register settings and stall patterns, predicts every payload byte and frame
// verdict in step with the accepted items and checks each result field by field
// ---------------------------------------------------------------------------
module crc_framed_packet_receiver_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cfpr_pkg::*;

  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_CYCLES   = 200;

  class deframe_checker;
    logic [7:0]  start_byte;
    logic [15:0] length_limit;
    logic [15:0] timeout_ticks;
    phase_t      phase;
    logic [7:0]  frame_cmd;
    logic [15:0] decl_len;
    logic [15:0] byte_pos;
    logic [15:0] idle_ticks;
    logic [31:0] crc_acc;
    logic [31:0] crc_rx;
    out_item_t   pending_events[$];
    int          errors;

    function new();
      start_byte    = START_BYTE_RST;
      length_limit  = LENGTH_LIMIT_RST;
      timeout_ticks = TIMEOUT_RST;
      phase         = PH_IDLE;
      frame_cmd     = '0;
      decl_len      = '0;
      byte_pos      = '0;
      idle_ticks    = '0;
      crc_acc       = CRC_INIT;
      crc_rx        = '0;
      errors        = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        CFG_START_BYTE:   start_byte = val[7:0];
        CFG_LENGTH_LIMIT: length_limit = val;
        CFG_TIMEOUT:      timeout_ticks = val;
        default: ;
      endcase
    endfunction

    // msb first, one data bit folded into the feedback per shift
    function logic [31:0] crc32_shift_byte(logic [31:0] c, logic [7:0] d);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
        fb = c[31] ^ d[i];
        c  = {c[30:0], 1'b0};
        if (fb) c = c ^ CRC_POLY;
      end
      return c;
    endfunction

    function void push_event(logic [2:0] ev, logic [7:0] pb, logic [15:0] pi);
      out_item_t e;
      e.event_res     = ev;
      e.payload_byte  = pb;
      e.payload_index = pi;
      e.command       = frame_cmd;
      e.frame_length  = decl_len;
      pending_events.push_back(e);
    endfunction

    function void take_item(in_item_t it);
      logic [7:0]  b;
      logic [15:0] idx;
      b = it.rx_byte;
      if (it.opcode == OP_TICK) begin
        if (idle_ticks != IDLE_MAX) idle_ticks++;
        if (idle_ticks > timeout_ticks && phase != PH_IDLE) begin
          phase = PH_IDLE;
          push_event(EV_TIMEOUT, 8'h00, 16'h0000);
        end
        return;
      end
      idle_ticks = '0;
      case (phase)
        PH_CMD: begin
          frame_cmd = b;
          crc_acc   = crc32_shift_byte(crc_acc, b);
          phase     = PH_LEN1;
        end
        PH_LEN1: begin
          decl_len = {8'h00, b};
          crc_acc  = crc32_shift_byte(crc_acc, b);
          phase    = PH_LEN2;
        end
        PH_LEN2: begin
          decl_len[15:8] = b;
          crc_acc        = crc32_shift_byte(crc_acc, b);
          if (decl_len >= length_limit) begin
            phase = PH_IDLE;
            push_event(EV_TOOLONG, 8'h00, 16'h0000);
          end else begin
            phase = (decl_len == 16'h0000) ? PH_CRC1 : PH_DATA;
          end
        end
        PH_DATA: begin
          idx      = byte_pos;
          crc_acc  = crc32_shift_byte(crc_acc, b);
          byte_pos = byte_pos + 16'd1;
          if (byte_pos >= decl_len) phase = PH_CRC1;
          push_event(EV_PAYLOAD, b, idx);
        end
        PH_CRC1: begin
          crc_rx = {24'h00_0000, b};
          phase  = PH_CRC2;
        end
        PH_CRC2: begin
          crc_rx[15:8] = b;
          phase        = PH_CRC3;
        end
        PH_CRC3: begin
          crc_rx[23:16] = b;
          phase         = PH_CRC4;
        end
        PH_CRC4: begin
          crc_rx[31:24] = b;
          phase         = PH_IDLE;
          push_event((crc_rx == crc_acc) ? EV_GOOD : EV_BADCRC, 8'h00, 16'h0000);
        end
        default: begin
          // hunting for the start byte, anything else is dropped
          phase = PH_IDLE;
          if (b == start_byte) begin
            phase     = PH_CMD;
            frame_cmd = '0;
            decl_len  = '0;
            byte_pos  = '0;
            crc_acc   = CRC_INIT;
            crc_rx    = '0;
          end
        end
      endcase
    endfunction

    function void compare_event(out_item_t got);
      out_item_t want;
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, got);
        errors++;
        return;
      end
      want = pending_events.pop_front();
      if (got.event_res !== want.event_res) begin
        $display("%0t: event_res expected %0d got %0d", $time, want.event_res, got.event_res);
        errors++;
      end
      if (got.payload_byte !== want.payload_byte) begin
        $display("%0t: payload_byte expected %h got %h", $time, want.payload_byte,
                 got.payload_byte);
        errors++;
      end
      if (got.payload_index !== want.payload_index) begin
        $display("%0t: payload_index expected %0d got %0d", $time, want.payload_index,
                 got.payload_index);
        errors++;
      end
      if (got.command !== want.command) begin
        $display("%0t: command expected %h got %h", $time, want.command, got.command);
        errors++;
      end
      if (got.frame_length !== want.frame_length) begin
        $display("%0t: frame_length expected %0d got %0d", $time, want.frame_length,
                 got.frame_length);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;

  deframe_checker sb;
  int tx_idle_pct = 15;
  int rx_idle_pct = 59;
  bit rx_hold_req = 1'b0;
  int items_sent  = 0;
  int stall_cycles = 0;

  crc_framed_packet_receiver_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // results are checked before the item of the same edge is noted
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.compare_event(out_data);
      if (in_valid && in_ready) sb.take_item(in_data);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // result side back-pressure, with a long hold-off when one is requested
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic send_item(logic opcode, logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_data.opcode  <= opcode;
    in_data.rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic wait_results_done();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  // a short run of ticks, mostly within the timeout
  task automatic tick_burst(int pct);
    int most;
    most = (sb.timeout_ticks < 6) ? int'(sb.timeout_ticks) + 1 : 6;
    if ($urandom_range(99) < pct) begin
      repeat ($urandom_range(most, 1)) send_item(OP_TICK, 8'($urandom_range(255)));
    end
  endtask

  task automatic send_frame(logic [7:0] cmd, logic [15:0] len, bit crc_ok, int tick_pct);
    logic [31:0] crc;
    logic [7:0]  hdr[3];
    logic [7:0]  b;
    hdr[0] = cmd;
    hdr[1] = len[7:0];
    hdr[2] = len[15:8];
    crc = CRC_INIT;
    send_item(OP_BYTE, sb.start_byte);
    tick_burst(tick_pct);
    for (int i = 0; i < 3; i++) begin
      crc = sb.crc32_shift_byte(crc, hdr[i]);
      send_item(OP_BYTE, hdr[i]);
      tick_burst(tick_pct);
    end
    if (len >= sb.length_limit) return;
    for (int i = 0; i < int'(len); i++) begin
      b   = 8'($urandom_range(255));
      crc = sb.crc32_shift_byte(crc, b);
      send_item(OP_BYTE, b);
      tick_burst(tick_pct);
    end
    if (!crc_ok) crc = crc ^ (32'h1 << $urandom_range(31));
    for (int k = 0; k < 4; k++) begin
      send_item(OP_BYTE, crc[8*k +: 8]);
      tick_burst(tick_pct);
    end
  endtask

  task automatic run_random(int n_items);
    int target;
    int top;
    target = items_sent + n_items;
    while (items_sent < target) begin
      case ($urandom_range(19))
        0: repeat ($urandom_range(3, 1)) send_item(OP_BYTE, 8'($urandom_range(255)));
        1: repeat ($urandom_range(4, 1)) send_item(OP_TICK, 8'($urandom_range(255)));
        2: begin
          // frame cut short and left to time out
          if (sb.timeout_ticks <= 40) begin
            send_item(OP_BYTE, sb.start_byte);
            repeat ($urandom_range(5, 1)) send_item(OP_BYTE, 8'($urandom_range(255)));
            repeat (int'(sb.timeout_ticks) + 1) send_item(OP_TICK, 8'($urandom_range(255)));
          end
        end
        3: begin
          top = int'(sb.length_limit) + $urandom_range(3);
          if (top > 65535) top = 65535;
          send_frame(8'($urandom_range(255)), 16'(top), 1'b1, 8);
        end
        default: begin
          top = ($urandom_range(15) == 0) ? 300 : 24;
          if (top > int'(sb.length_limit) - 1) top = int'(sb.length_limit) - 1;
          top = ($urandom_range(7) == 0) ? 0 : $urandom_range(top);
          send_frame(8'($urandom_range(255)), 16'(top), $urandom_range(99) >= 15, 8);
        end
      endcase
    end
  endtask

  task automatic run_phase(logic [15:0] start, logic [15:0] limit, logic [15:0] tmo,
                           int txp, int rxp);
    wait_results_done();
    write_cfg(CFG_START_BYTE, start);
    write_cfg(CFG_LENGTH_LIMIT, limit);
    write_cfg(CFG_TIMEOUT, tmo);
    tx_idle_pct = txp;
    rx_idle_pct = rxp;
    run_random(230);
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: stray byte and tick while hunting, zero length, bad crc, length at the limit
    send_item(OP_BYTE, 8'h00);
    send_item(OP_TICK, 8'hFF);
    send_frame(8'hFF, 16'h0000, 1'b1, 0);
    send_frame(8'h00, 16'h0001, 1'b0, 0);
    send_frame(8'h7E, 16'h0100, 1'b1, 0);
    wait_results_done();
    write_cfg(CFG_UNUSED, 16'hFFFF);
    write_cfg(CFG_TIMEOUT, 16'd0);
    send_item(OP_BYTE, START_BYTE_RST);
    send_item(OP_BYTE, 8'h3C);
    send_item(OP_TICK, 8'h00);

    run_phase(16'hC300, 16'd1, 16'd0, 15, 59);
    run_phase(16'h007E, 16'd64, 16'd8, 15, 59);
    run_phase(16'h00FF, 16'hFFFF, 16'hFFFF, 59, 15);
    run_phase(16'h3C55, 16'd40, 16'd3, 59, 15);
    run_phase(16'h00A5, 16'd300, 16'd20, 0, 0);

    // receiver holds off while a long payload keeps coming
    rx_hold_req = 1'b1;
    send_frame(8'($urandom_range(255)), 16'd60, 1'b1, 0);

    run_phase(16'h00C3, 16'hFFFF, 16'hFFFF, 0, 0);

    // idle count runs past a lowered timeout, which trips on the next tick
    wait_results_done();
    send_item(OP_BYTE, sb.start_byte);
    send_item(OP_BYTE, 8'h81);
    repeat (40) send_item(OP_TICK, 8'($urandom_range(255)));
    wait_results_done();
    write_cfg(CFG_TIMEOUT, 16'd20);
    send_item(OP_TICK, 8'h00);

    wait_results_done();
    if (sb.errors == 0 && sb.pending_events.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
